/* hw/rtl/nec_pkg.sv */
`timescale 1ns / 1ps

package nec_pkg;

	localparam int FRAME_BITS = 32;
	localparam int BIT_IDX_W  = $clog2(FRAME_BITS);
	localparam int BIT_CNT_W  = 6;
	localparam int TICK_W     = 10;
	localparam int TIME_W     = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	localparam logic [TIME_W-1:0] BIT_BOUNDARY_RST = 16'd1500;
	localparam logic [TICK_W-1:0] HOLD_TICKS_RST   = 10'd100;
	localparam logic [TICK_W-1:0] SETTLE_TICKS_RST = 10'd30;
	localparam logic [TICK_W-1:0] REPEAT_TICKS_RST = 10'd200;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_DELAY  = 2'd1,
		PH_REPEAT = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		MODE_TICK   = 2'd0,
		MODE_SAMPLE = 2'd1,
		MODE_RESET  = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BIT_BOUNDARY     = 3'd0,
		REG_EXTENDED_ADDRESS = 3'd1,
		REG_HOLD_TICKS       = 3'd2,
		REG_SETTLE_TICKS     = 3'd3,
		REG_REPEAT_TICKS     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [TIME_W-1:0] pulse_time;
	} item_t;

	typedef struct packed {
		logic       key_event;
		logic [7:0] keycode;
		logic       frame_error;
		logic [1:0] phase;
	} result_t;

	typedef struct packed {
		logic [TIME_W-1:0] bit_boundary;
		logic              extended_address;
		logic [TICK_W-1:0] hold_ticks;
		logic [TICK_W-1:0] settle_ticks;
		logic [TICK_W-1:0] repeat_ticks;
	} cfg_t;

endpackage

/* hw/rtl/nec_cfg_regs.sv */
`timescale 1ns / 1ps

module nec_cfg_regs import nec_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_boundary     <= BIT_BOUNDARY_RST;
			cfg_q.extended_address <= 1'b0;
			cfg_q.hold_ticks       <= HOLD_TICKS_RST;
			cfg_q.settle_ticks     <= SETTLE_TICKS_RST;
			cfg_q.repeat_ticks     <= REPEAT_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BIT_BOUNDARY:     cfg_q.bit_boundary     <= cfg_data[TIME_W-1:0];
				REG_EXTENDED_ADDRESS: cfg_q.extended_address <= cfg_data[0];
				REG_HOLD_TICKS:       cfg_q.hold_ticks       <= cfg_data[TICK_W-1:0];
				REG_SETTLE_TICKS:     cfg_q.settle_ticks     <= cfg_data[TICK_W-1:0];
				REG_REPEAT_TICKS:     cfg_q.repeat_ticks     <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/nec_frame_core.sv */
`timescale 1ns / 1ps

module nec_frame_core import nec_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item_s1,
	input  cfg_t    cfg,
	output result_t result_s2
);

	phase_t                 phase_q, phase_n;
	logic                   ret_q, ret_n;
	logic [TICK_W-1:0]      cd_q, cd_n;
	logic [FRAME_BITS-1:0]  fb_q, fb_n;
	logic [BIT_CNT_W-1:0]   bc_q, bc_n, bc_inc;
	logic [7:0]             lk_q, lk_n;
	result_t                res_n, res_s2;
	logic [7:0]             a_b, na_b, c_b, nc_b;
	logic                   ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ret_q   <= 1'b0;
			cd_q    <= '0;
			fb_q    <= '0;
			bc_q    <= '0;
			lk_q    <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			ret_q   <= ret_n;
			cd_q    <= cd_n;
			fb_q    <= fb_n;
			bc_q    <= bc_n;
			lk_q    <= lk_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res_n;
		end
	end

	// frame word with the incoming sample merged in, checked on the last bit
	always_comb begin
		fb_n = fb_q;
		fb_n[bc_q[BIT_IDX_W-1:0]] = (item_s1.pulse_time > cfg.bit_boundary);
	end

	assign bc_inc = bc_q + BIT_CNT_W'(1);
	assign a_b    = fb_n[7:0];
	assign na_b   = fb_n[15:8];
	assign c_b    = fb_n[23:16];
	assign nc_b   = fb_n[31:24];
	assign ok     = (nc_b == ~c_b) && (cfg.extended_address || (na_b == ~a_b));

	always_comb begin
		phase_n = phase_q;
		ret_n   = ret_q;
		cd_n    = cd_q;
		bc_n    = bc_q;
		lk_n    = lk_q;
		res_n   = '0;
		case (item_s1.mode)
			MODE_TICK: begin
				if (phase_q == PH_DELAY) begin
					if (cd_q <= TICK_W'(1)) begin
						cd_n = '0;
						bc_n = '0;
						if (ret_q) begin
							phase_n = PH_REPEAT;
							cd_n    = cfg.repeat_ticks;
						end else begin
							phase_n = PH_IDLE;
							lk_n    = '0;
						end
					end else begin
						cd_n = cd_q - TICK_W'(1);
					end
				end else if (phase_q == PH_REPEAT) begin
					if (cd_q <= TICK_W'(1)) begin
						phase_n = PH_DELAY;
						cd_n    = cfg.settle_ticks;
						ret_n   = 1'b0;
						bc_n    = '0;
					end else begin
						cd_n = cd_q - TICK_W'(1);
					end
				end
			end
			MODE_SAMPLE: begin
				if (phase_q != PH_DELAY) begin
					bc_n = bc_inc;
					if (bc_inc >= BIT_CNT_W'(FRAME_BITS)) begin
						lk_n = c_b;
						bc_n = '0;
						if (ok) begin
							res_n.key_event = 1'b1;
							res_n.keycode   = c_b;
							phase_n         = PH_DELAY;
							cd_n            = cfg.hold_ticks;
							ret_n           = 1'b1;
						end else begin
							res_n.frame_error = 1'b1;
							if (phase_q == PH_IDLE) begin
								phase_n = PH_DELAY;
								cd_n    = cfg.settle_ticks;
								ret_n   = 1'b0;
							end
						end
					end
				end
			end
			MODE_RESET: begin
				if (phase_q == PH_IDLE) begin
					lk_n = '0;
					bc_n = '0;
				end else if (phase_q == PH_REPEAT) begin
					res_n.key_event = 1'b1;
					res_n.keycode   = lk_q;
					phase_n         = PH_DELAY;
					cd_n            = cfg.settle_ticks;
					ret_n           = 1'b1;
					bc_n            = '0;
				end
			end
			default: ;
		endcase
		res_n.phase = phase_n;
	end

	assign result_s2 = res_s2;

endmodule

/* hw/rtl/nec_ir_frame_decoder.sv */
`timescale 1ns / 1ps

// NEC IR frame decoder.
// Input channel (item_valid/item_ready/item): one beat per tick, pulse timing
// sample or reset event. Output channel (result_valid/result_ready/result):
// exactly one result beat per input beat, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index;
// only write while no beat is in flight.
// Pipeline: input register, then decode and phase update into the result
// register. An accepted beat waits in the input register until the result
// register is free or being taken. Throughput is one beat per cycle while
// result_ready stays high; the phase update is a loop through the phase register.
// A stalled result holds in the output register; the input register still
// takes one more beat, then item_ready drops until the result is taken.
// Reset clears the phase machine to idle, empties both registers and loads
// the default timing thresholds.
module nec_ir_frame_decoder import nec_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg;
	item_t item_s1;
	logic  valid_s1, valid_s2;
	logic  step;

	assign step       = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (step) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	nec_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	nec_frame_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item_s1   (item_s1),
		.cfg       (cfg),
		.result_s2 (result)
	);

	assign result_valid = valid_s2;

endmodule

/* bench/tb_nec_ir_frame_decoder.sv */
`timescale 1ns / 1ps

module tb_nec_ir_frame_decoder;
	import nec_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;  // no function, must be ignored
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_STALL_AT  = 60;
	localparam int LONG_STALL_LEN = 64;
	localparam int DRAIN_CYCLES   = 6;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_ready;
	item_t                 item         = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	nec_ir_frame_decoder DUT (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// decoder mirror
	cfg_t                  cfg_mirror;
	phase_t                cur_phase;
	logic                  back_to_repeat;
	logic [TICK_W-1:0]     countdown;
	logic [FRAME_BITS-1:0] frame_word;
	logic [BIT_CNT_W-1:0]  bits_seen;
	logic [7:0]            last_cmd;

	item_t   pending_items[$];
	result_t expected_results[$];
	int      errors = 0;

	function automatic void reset_mirror();
		cfg_mirror     = {BIT_BOUNDARY_RST, 1'b0, HOLD_TICKS_RST, SETTLE_TICKS_RST,
			REPEAT_TICKS_RST};
		cur_phase      = PH_IDLE;
		back_to_repeat = 1'b0;
		countdown      = '0;
		frame_word     = '0;
		bits_seen      = '0;
		last_cmd       = '0;
	endfunction

	function automatic void enter_idle_phase();
		cur_phase = PH_IDLE;
		last_cmd  = '0;
		bits_seen = '0;
	endfunction

	function automatic void enter_repeat_phase();
		cur_phase = PH_REPEAT;
		countdown = cfg_mirror.repeat_ticks;
		bits_seen = '0;
	endfunction

	function automatic void enter_delay_phase(input logic [TICK_W-1:0] ticks, input logic to_repeat);
		cur_phase      = PH_DELAY;
		countdown      = ticks;
		back_to_repeat = to_repeat;
		bits_seen      = '0;
	endfunction

	// a zero count expires on the next tick, same as one
	function automatic logic countdown_done();
		if (countdown <= 1) begin
			countdown = '0;
			return 1'b1;
		end
		countdown = countdown - 1'b1;
		return 1'b0;
	endfunction

	function automatic result_t decode_item(input item_t it);
		result_t r;
		logic    frame_ok;
		r = '0;
		case (it.mode)
		MODE_TICK: begin
			if (cur_phase == PH_DELAY) begin
				if (countdown_done()) begin
					if (back_to_repeat)
						enter_repeat_phase();
					else
						enter_idle_phase();
				end
			end else if (cur_phase == PH_REPEAT) begin
				if (countdown_done())
					enter_delay_phase(cfg_mirror.settle_ticks, 1'b0);
			end
		end
		MODE_SAMPLE: begin
			if (cur_phase != PH_DELAY) begin
				frame_word[bits_seen[BIT_IDX_W-1:0]] = it.pulse_time > cfg_mirror.bit_boundary;
				bits_seen = bits_seen + 1'b1;
				if (bits_seen >= FRAME_BITS) begin
					frame_ok = frame_word[31:24] == ~frame_word[23:16];
					if (!cfg_mirror.extended_address && frame_word[15:8] != ~frame_word[7:0])
						frame_ok = 1'b0;
					last_cmd  = frame_word[23:16];
					bits_seen = '0;
					if (frame_ok) begin
						r.key_event = 1'b1;
						r.keycode   = frame_word[23:16];
						enter_delay_phase(cfg_mirror.hold_ticks, 1'b1);
					end else begin
						r.frame_error = 1'b1;
						// a bad frame in repeat leaves the window running
						if (cur_phase == PH_IDLE)
							enter_delay_phase(cfg_mirror.settle_ticks, 1'b0);
					end
				end
			end
		end
		MODE_RESET: begin
			if (cur_phase == PH_IDLE) begin
				enter_idle_phase();
			end else if (cur_phase == PH_REPEAT) begin
				r.key_event = 1'b1;
				r.keycode   = last_cmd;
				enter_delay_phase(cfg_mirror.settle_ticks, 1'b1);
			end
		end
		default: ;
		endcase
		r.phase = cur_phase;
		return r;
	endfunction

	// driver
	int   send_gap   = 0;
	bit   send_quiet = 1'b0;
	logic next_valid;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			send_gap = 0;
		end else begin
			next_valid = item_valid;
			if (item_valid && item_ready) begin
				expected_results.push_back(decode_item(item));
				next_valid = 1'b0;
				if ($urandom_range(0, 15) == 0)
					send_quiet = !send_quiet;
				send_gap = send_quiet ? 0 : $urandom_range(0, 4);
			end
			if (!next_valid) begin
				if (send_gap != 0) begin
					send_gap--;
				end else if (pending_items.size() != 0) begin
					item <= pending_items.pop_front();
					next_valid = 1'b1;
				end
			end
			item_valid <= next_valid;
		end
	end

	// monitor
	int      recv_gap   = 0;
	int      long_hold  = 0;
	int      beats_seen = 0;
	bit      recv_quiet = 1'b0;
	result_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			recv_gap  = 0;
			long_hold = 0;
		end else begin
			if (result_valid && result_ready) begin
				beats_seen++;
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected: %p", result);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (result.key_event !== want.key_event) begin
						$error("key_event: expected %0d, got %0d", want.key_event, result.key_event);
						errors++;
					end
					if (result.keycode !== want.keycode) begin
						$error("keycode: expected %0h, got %0h", want.keycode, result.keycode);
						errors++;
					end
					if (result.frame_error !== want.frame_error) begin
						$error("frame_error: expected %0d, got %0d", want.frame_error,
							result.frame_error);
						errors++;
					end
					if (result.phase !== want.phase) begin
						$error("phase: expected %0d, got %0d", want.phase, result.phase);
						errors++;
					end
				end
				if ($urandom_range(0, 15) == 0)
					recv_quiet = !recv_quiet;
				recv_gap = recv_quiet ? 0 : $urandom_range(0, 4);
				// one long back-pressure window while the sender keeps going
				if (beats_seen == LONG_STALL_AT)
					long_hold = LONG_STALL_LEN;
			end
			if (long_hold != 0) begin
				long_hold--;
				result_ready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	int stuck_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles == WATCHDOG_LIMIT) begin
				$error("no beat moved for %0d cycles", WATCHDOG_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		REG_BIT_BOUNDARY:     cfg_mirror.bit_boundary     = val;
		REG_EXTENDED_ADDRESS: cfg_mirror.extended_address = val[0];
		REG_HOLD_TICKS:       cfg_mirror.hold_ticks       = val[TICK_W-1:0];
		REG_SETTLE_TICKS:     cfg_mirror.settle_ticks     = val[TICK_W-1:0];
		REG_REPEAT_TICKS:     cfg_mirror.repeat_ticks     = val[TICK_W-1:0];
		default: ;
		endcase
	endtask

	task automatic set_config(input logic [TIME_W-1:0] boundary, input logic ext,
			input logic [TICK_W-1:0] hold, input logic [TICK_W-1:0] settle,
			input logic [TICK_W-1:0] rpt);
		write_reg(REG_BIT_BOUNDARY, boundary);
		write_reg(REG_EXTENDED_ADDRESS, CFG_DATA_W'(ext));
		write_reg(REG_HOLD_TICKS, CFG_DATA_W'(hold));
		write_reg(REG_SETTLE_TICKS, CFG_DATA_W'(settle));
		write_reg(REG_REPEAT_TICKS, CFG_DATA_W'(rpt));
	endtask

	// only called with nothing in flight
	task automatic pulse_reset();
		@(posedge clk);
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		reset_mirror();
		arst_n <= 1'b1;
	endtask

	// wait on the falling edge so every beat of the edge before has landed
	task automatic drain();
		@(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic push_item(input logic [1:0] mode, input logic [TIME_W-1:0] pt);
		item_t t;
		t.mode       = mode;
		t.pulse_time = pt;
		pending_items.push_back(t);
	endtask

	task automatic push_ticks(input int n);
		repeat (n) push_item(MODE_TICK, TIME_W'($urandom));
	endtask

	function automatic logic [TIME_W-1:0] bit_timing(input logic one);
		int bb;
		bb = cfg_mirror.bit_boundary;
		if (one) begin
			if (bb == 65535)
				return 16'hFFFF;  // nothing can decode as a one
			return TIME_W'($urandom_range(65535, bb + 1));
		end
		return TIME_W'($urandom_range(bb, 0));
	endfunction

	function automatic logic [FRAME_BITS-1:0] frame_of(input logic [7:0] addr,
			input logic [7:0] cmd, input bit bad_addr, input bit bad_cmd);
		logic [7:0] addr_chk;
		logic [7:0] cmd_chk;
		addr_chk = ~addr ^ (bad_addr ? 8'($urandom_range(1, 255)) : 8'h00);
		cmd_chk  = ~cmd ^ (bad_cmd ? 8'($urandom_range(1, 255)) : 8'h00);
		return {cmd_chk, cmd, addr_chk, addr};
	endfunction

	// edge_vals: odd bits use 0 / all ones, even bits sit right on the threshold
	task automatic push_word(input logic [FRAME_BITS-1:0] w, input bit edge_vals);
		logic [TIME_W-1:0] t;
		for (int i = 0; i < FRAME_BITS; i++) begin
			if (!edge_vals)
				t = bit_timing(w[i]);
			else if (i[0])
				t = w[i] ? 16'hFFFF : 16'h0000;
			else
				t = w[i] ? cfg_mirror.bit_boundary + 1'b1 : cfg_mirror.bit_boundary;
			push_item(MODE_SAMPLE, t);
		end
	endtask

	task automatic fill_random(input int count);
		int made;
		int pick;
		int len;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				push_word(frame_of(8'($urandom), 8'($urandom), 1'b0, 1'b0), 1'b0);
				made += FRAME_BITS;
			end else if (pick < 55) begin
				push_word(frame_of(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom)),
					1'b0);
				made += FRAME_BITS;
			end else if (pick < 62) begin
				// truncated frame, then a reset event to resync
				len = $urandom_range(1, FRAME_BITS - 1);
				repeat (len) push_item(MODE_SAMPLE, TIME_W'($urandom));
				push_item(MODE_RESET, TIME_W'($urandom));
				made += len + 1;
			end else if (pick < 85) begin
				len = $urandom_range(1, 12);
				push_ticks(len);
				made += len;
			end else if (pick < 95) begin
				push_item(MODE_RESET, TIME_W'($urandom));
				made++;
			end else begin
				push_item(MODE_SPARE, TIME_W'($urandom));
			end
		end
	endtask

	function automatic logic [TICK_W-1:0] short_ticks();
		return TICK_W'($urandom_range(1, 8));
	endfunction

	initial begin
		reset_mirror();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed walk through the phases, default threshold
		write_reg(REG_HOLD_TICKS, 16'd2);
		write_reg(REG_SETTLE_TICKS, 16'd3);
		write_reg(REG_REPEAT_TICKS, 16'd4);
		push_item(MODE_TICK, 16'h0000);
		push_item(MODE_RESET, 16'hFFFF);
		push_item(MODE_SPARE, 16'h5A5A);
		push_word(frame_of(8'h00, 8'hFF, 1'b0, 1'b0), 1'b1);
		push_item(MODE_SAMPLE, 16'hFFFF);  // ignored in delay
		push_item(MODE_RESET, 16'h0000);   // ignored in delay
		push_ticks(2);
		push_word(frame_of(8'h12, 8'h34, 1'b0, 1'b1), 1'b1);  // bad frame inside repeat
		push_item(MODE_RESET, 16'h0000);   // repeats the last command byte, here the one from the bad frame
		push_ticks(3);
		push_ticks(4);                      // repeat window runs out
		push_ticks(3);
		push_word(frame_of(8'hA5, 8'h5A, 1'b1, 1'b0), 1'b1);  // address check fails in idle
		drain();

		set_config(16'd0, 1'b0, 10'd1, 10'd1, 10'd1);
		fill_random(50);
		drain();

		// longest delays; address check off
		set_config(16'hFFFE, 1'b1, 10'd1023, 10'd1023, 10'd1023);
		push_word(frame_of(8'($urandom), 8'($urandom), 1'b1, 1'b0), 1'b0);
		push_ticks(60);
		drain();
		// the long hold is still counting down; start over from reset
		pulse_reset();

		// threshold at max: no timing is a one
		set_config(16'hFFFF, 1'($urandom_range(0, 1)), short_ticks(), short_ticks(),
			short_ticks());
		fill_random(40);
		drain();

		repeat (3) begin
			set_config(TIME_W'($urandom_range(1, 65534)), 1'($urandom_range(0, 1)),
				short_ticks(), short_ticks(), short_ticks());
			fill_random(60);
			drain();
		end

		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
